[hw/rtl/multiplexed_seven_segment_number_defines.svh]
// Assertion macros shared by the RTL. Each expects i_clk and i_rst_n in scope.
`ifndef MULTIPLEXED_SEVEN_SEGMENT_NUMBER_DEFINES_SVH
`define MULTIPLEXED_SEVEN_SEGMENT_NUMBER_DEFINES_SVH

// Same-cycle implication.
`define MSSN_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define MSSN_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Invariant at every edge out of reset.
`define MSSN_ASSERT_HOLD(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error(msg);

`endif

[hw/rtl/mssn_pkg.sv]
package mssn_pkg;

    localparam int VALUE_W        = 27;
    localparam int SEL_W          = 8;
    localparam int SEG_W          = 8;
    localparam int MAX_DIGITS     = 8;
    localparam int POS_W          = 3;
    localparam int DEF_NUM_DIGITS = 8;
    localparam int RADIX          = 10;
    localparam int Q_DEPTH        = 2;
    localparam int Q_PTR_W        = 1;
    localparam int Q_CNT_W        = 2;

    localparam logic [SEG_W-1:0] POINT_MASK = 8'h80;

    localparam logic [SEG_W-1:0] FONT [16] = '{
        8'h3f, 8'h06, 8'h5b, 8'h4f,
        8'h66, 8'h6d, 8'h7d, 8'h07,
        8'h7f, 8'h6f, 8'h77, 8'h7c,
        8'h39, 8'h5e, 8'h79, 8'h71
    };

    typedef enum logic [1:0] {
        FS_IDLE,
        FS_CONV,
        FS_PUSH
    } t_front_state;

    // Largest number that n decimal digits can show.
    function automatic int digits_limit(input int n);
        int lim;
        lim = 1;
        for (int k = 0; k < n; k++) begin
            lim = lim * RADIX;
        end
        return lim - 1;
    endfunction

    // Seven-segment pattern, point always dark.
    function automatic logic [SEG_W-1:0] seg_font(input logic [3:0] digit);
        return FONT[digit] & ~POINT_MASK;
    endfunction

endpackage

[hw/rtl/mssn_in_if.sv]
interface mssn_in_if import mssn_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [VALUE_W-1:0] value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

[hw/rtl/mssn_out_if.sv]
interface mssn_out_if import mssn_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [SEL_W-1:0] digit_select;
    logic [SEG_W-1:0] segments;
    logic             last_digit;

    modport source (output valid, output digit_select, output segments, output last_digit,
                    input ready);
    modport sink   (input valid, input digit_select, input segments, input last_digit,
                    output ready);
endinterface

[hw/rtl/multiplexed_seven_segment_number.sv]
// Seven-segment number driver. Each input word carries one unsigned number;
// values above the largest that NUM_DIGITS decimal digits can show are clamped
// to all nines, and a zero word is taken and produces nothing. The number is
// converted to BCD by a shift-and-add-3 engine, one input bit per cycle; the
// front end then hands the BCD word to a two-entry queue and takes no new word
// until the queue has taken it. The back end drains the queue and emits one
// output word per shown digit, least significant first, at one word per cycle
// when the sink keeps ready high: an active-low one-cold digit select (bit 0
// is the rightmost digit), the hex-font segment pattern with the point dark,
// and last_digit set on the most significant nonzero digit. Leading zeros are
// not shown. The conversion loop sets the sustained rate; the back end runs a
// number's digits while the next one converts.
module multiplexed_seven_segment_number import mssn_pkg::*; #(
    parameter int NUM_DIGITS = DEF_NUM_DIGITS
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    mssn_in_if.sink    i_in,
    mssn_out_if.source o_out
);

    localparam int BCD_W = 4 * NUM_DIGITS;

    // Front to queue
    logic             push_valid;
    logic             push_ready;
    logic [BCD_W-1:0] push_bcd;

    // Queue to back
    logic             q_valid;
    logic             q_pop;
    logic [BCD_W-1:0] q_bcd;

    // Clamp, drop zero, convert to BCD.
    mssn_front #(
        .NUM_DIGITS (NUM_DIGITS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (i_in),
        .o_push_valid (push_valid),
        .i_push_ready (push_ready),
        .o_push_bcd   (push_bcd)
    );

    // Hold converted numbers so conversion and emission overlap.
    mssn_queue #(
        .NUM_DIGITS (NUM_DIGITS)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (push_valid),
        .o_push_ready (push_ready),
        .i_push_bcd   (push_bcd),
        .o_pop_valid  (q_valid),
        .i_pop        (q_pop),
        .o_pop_bcd    (q_bcd)
    );

    // Walk the digits and drive the registered output.
    mssn_back #(
        .NUM_DIGITS (NUM_DIGITS)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .o_pop     (q_pop),
        .i_q_bcd   (q_bcd),
        .o_out     (o_out)
    );

endmodule

[hw/rtl/mssn_front.sv]
module mssn_front import mssn_pkg::*; #(
    parameter int NUM_DIGITS = DEF_NUM_DIGITS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    mssn_in_if.sink               i_in,
    output logic                  o_push_valid,
    input  logic                  i_push_ready,
    output logic [4*NUM_DIGITS-1:0] o_push_bcd
);

    localparam int BCD_W = 4 * NUM_DIGITS;
    localparam int CNT_W = $clog2(VALUE_W);
    localparam logic [VALUE_W-1:0] LIMIT = VALUE_W'(digits_limit(NUM_DIGITS));
    localparam logic [CNT_W-1:0]   LAST_CNT = CNT_W'(VALUE_W - 1);

    t_front_state       r_state, n_state;
    logic [VALUE_W-1:0] r_bin, n_bin;
    logic [BCD_W-1:0]   r_bcd, n_bcd;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic [VALUE_W-1:0] sat_value;
    logic [BCD_W-1:0]   dabbed;

    assign sat_value = (i_in.value > LIMIT) ? LIMIT : i_in.value;

    // Add 3 to every digit of 5 or more before the shift.
    always_comb begin
        for (int d = 0; d < NUM_DIGITS; d++) begin
            if (r_bcd[4*d +: 4] >= 4'd5) begin
                dabbed[4*d +: 4] = r_bcd[4*d +: 4] + 4'd3;
            end else begin
                dabbed[4*d +: 4] = r_bcd[4*d +: 4];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= FS_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_bin <= n_bin;
        r_bcd <= n_bcd;
        r_cnt <= n_cnt;
    end

    always_comb begin
        n_state      = r_state;
        n_bin        = r_bin;
        n_bcd        = r_bcd;
        n_cnt        = r_cnt;
        i_in.ready   = (r_state == FS_IDLE);
        o_push_valid = (r_state == FS_PUSH);
        case (r_state)
            FS_IDLE: begin
                // A zero word shows nothing: drop it here.
                if (i_in.valid && (sat_value != '0)) begin
                    n_bin   = sat_value;
                    n_bcd   = '0;
                    n_cnt   = '0;
                    n_state = FS_CONV;
                end
            end
            FS_CONV: begin
                n_bin = r_bin << 1;
                n_bcd = {dabbed[BCD_W-2:0], r_bin[VALUE_W-1]};
                n_cnt = r_cnt + CNT_W'(1);
                if (r_cnt == LAST_CNT) begin
                    n_state = FS_PUSH;
                end
            end
            FS_PUSH: begin
                if (i_push_ready) begin
                    n_state = FS_IDLE;
                end
            end
            default: begin
                n_state = FS_IDLE;
            end
        endcase
    end

    assign o_push_bcd = r_bcd;

endmodule

[hw/rtl/mssn_queue.sv]
`include "multiplexed_seven_segment_number_defines.svh"

module mssn_queue import mssn_pkg::*; #(
    parameter int NUM_DIGITS = DEF_NUM_DIGITS
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_push_valid,
    output logic                    o_push_ready,
    input  logic [4*NUM_DIGITS-1:0] i_push_bcd,
    output logic                    o_pop_valid,
    input  logic                    i_pop,
    output logic [4*NUM_DIGITS-1:0] o_pop_bcd
);

    localparam int BCD_W = 4 * NUM_DIGITS;

    logic [BCD_W-1:0]   r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wptr, r_rptr;
    logic [Q_CNT_W-1:0] r_count;
    logic               push, pop;

    assign o_push_ready = (r_count != Q_CNT_W'(Q_DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign push         = i_push_valid && o_push_ready;
    assign pop          = i_pop && o_pop_valid;
    assign o_pop_bcd    = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wptr] <= i_push_bcd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (push) begin
                r_wptr <= r_wptr + Q_PTR_W'(1);
            end
            if (pop) begin
                r_rptr <= r_rptr + Q_PTR_W'(1);
            end
            if (push && !pop) begin
                r_count <= r_count + Q_CNT_W'(1);
            end else if (pop && !push) begin
                r_count <= r_count - Q_CNT_W'(1);
            end
        end
    end

    `MSSN_ASSERT_HOLD(a_q_bound, r_count <= Q_CNT_W'(Q_DEPTH), "queue fill out of range")
    `MSSN_ASSERT_NXT(a_q_grow, push && !pop, r_count == $past(r_count) + Q_CNT_W'(1), "fill did not grow")
    `MSSN_ASSERT_NXT(a_q_shrink, pop && !push, r_count == $past(r_count) - Q_CNT_W'(1), "fill did not shrink")

endmodule

[hw/rtl/mssn_back.sv]
`include "multiplexed_seven_segment_number_defines.svh"

module mssn_back import mssn_pkg::*; #(
    parameter int NUM_DIGITS = DEF_NUM_DIGITS
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_q_valid,
    output logic                    o_pop,
    input  logic [4*NUM_DIGITS-1:0] i_q_bcd,
    mssn_out_if.source              o_out
);

    localparam int BCD_W = 4 * NUM_DIGITS;

    logic             r_busy, n_busy;
    logic [BCD_W-1:0] r_bcd, n_bcd;
    logic [POS_W-1:0] r_pos, n_pos;
    logic             r_out_valid, n_out_valid;
    logic [SEL_W-1:0] r_out_sel, n_out_sel;
    logic [SEG_W-1:0] r_out_seg, n_out_seg;
    logic             r_out_last, n_out_last;
    logic             load, is_last;

    assign o_pop   = i_q_valid && !r_busy;
    assign load    = r_busy && (!r_out_valid || o_out.ready);
    assign is_last = ((r_bcd >> 4) == '0);

    always_comb begin
        n_busy      = r_busy;
        n_bcd       = r_bcd;
        n_pos       = r_pos;
        n_out_valid = r_out_valid;
        n_out_sel   = r_out_sel;
        n_out_seg   = r_out_seg;
        n_out_last  = r_out_last;
        if (o_pop) begin
            n_busy = 1'b1;
            n_bcd  = i_q_bcd;
            n_pos  = '0;
        end
        if (load) begin
            n_out_valid = 1'b1;
            n_out_sel   = ~(SEL_W'(1) << r_pos);
            n_out_seg   = seg_font(r_bcd[3:0]);
            n_out_last  = is_last;
            n_bcd       = r_bcd >> 4;
            n_pos       = r_pos + POS_W'(1);
            if (is_last) begin
                n_busy = 1'b0;
            end
        end else if (o_out.ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_busy      <= n_busy;
            r_out_valid <= n_out_valid;
        end
        r_bcd      <= n_bcd;
        r_pos      <= n_pos;
        r_out_sel  <= n_out_sel;
        r_out_seg  <= n_out_seg;
        r_out_last <= n_out_last;
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.digit_select = r_out_sel;
    assign o_out.segments     = r_out_seg;
    assign o_out.last_digit   = r_out_last;

    `MSSN_ASSERT_IMP(a_busy_nonzero, r_busy, r_bcd != '0, "busy with no digits left")
    `MSSN_ASSERT_IMP(a_more_pending, r_out_valid && !r_out_last, r_busy, "run ended early")
    `MSSN_ASSERT_NXT(a_pop_starts, o_pop, r_busy, "pop did not start a run")

endmodule
